/* rtl/sfd_pkg.sv */
package sfd_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 64;
  localparam int DEF_HEADER_BYTES    = 5;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 2);
  localparam int NUM_BANKS     = 2;
  localparam int ADDR_W        = IDX_W + 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] ACK_LEN_RESET  = 7'd1;
  localparam logic [CFG_W-1:0] MEAS_LEN_RESET = 7'd40;

  localparam logic REG_ACK_LENGTH  = 1'b0;
  localparam logic REG_MEAS_LENGTH = 1'b1;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] ESC_XON   = 8'h31;
  localparam logic [7:0] ESC_XOFF  = 8'h33;
  localparam logic [7:0] XON_BYTE  = 8'h11;
  localparam logic [7:0] XOFF_BYTE = 8'h13;

  typedef enum logic [1:0] {
    STATUS_REJECT = 2'd0,
    STATUS_ACK    = 2'd1,
    STATUS_MEAS   = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic             bank;
  } verdict_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } unesc_t;

  function automatic unesc_t unescape(input logic [7:0] code);
    unesc_t r;
    r.hit = 1'b1;
    unique case (code)
      ESC_FLAG: r.value = FLAG_BYTE;
      ESC_ESC:  r.value = ESC_BYTE;
      ESC_XON:  r.value = XON_BYTE;
      ESC_XOFF: r.value = XOFF_BYTE;
      default: begin
        r.hit   = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/stuffed_frame_deframer.sv */
// Receives byte-stuffed sensor frames one raw byte per transfer, frame_end_i marking the
// last byte, and answers each frame with a reject, an acknowledge, or a measurement whose
// unstuffed payload bytes follow one per transfer, last_result_o marking the final one.
// A byte is taken every cycle unless stalled and gives no result until its frame ends;
// the verdict leaves a two-entry queue and a payload streams from a two-bank store at
// one byte per cycle unless out_stall_i is high. A new frame may be received while the
// previous measurement is still streaming; input stalls only when the verdict queue is
// full or both store banks still hold measurements awaiting output. Configuration must
// be written through cfg_we_i while no frame is in flight; the block does not enforce it.
module stuffed_frame_deframer #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::DEF_MAX_FRAME_BYTES,
  parameter int HEADER_BYTES    = sfd_pkg::DEF_HEADER_BYTES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [sfd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      frame_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                frame_status_o,
  output logic [7:0]                payload_byte_o,
  output logic                      last_result_o
);
  import sfd_pkg::*;

  logic [CFG_W-1:0] ack_len_q, meas_len_q;
  logic             push, pop, q_empty, q_full;
  verdict_t         push_data, head;
  wr_t              wr_s;
  rel_t             rel_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_len_q  <= ACK_LEN_RESET;
      meas_len_q <= MEAS_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ACK_LENGTH:  ack_len_q  <= cfg_wdata_i;
        REG_MEAS_LENGTH: meas_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sfd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .ack_len_i   (ack_len_q),
    .meas_len_i  (meas_len_q),
    .queue_full_i(q_full),
    .rel_i       (rel_s),
    .push_o      (push),
    .verdict_o   (push_data),
    .wr_o        (wr_s)
  );

  sfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  sfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr_s),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .rel_o         (rel_s),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_status_o(frame_status_o),
    .payload_byte_o(payload_byte_o),
    .last_result_o (last_result_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("Verdict pushed into a full queue.");

  a_no_write_to_draining_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rel_s.valid && wr_s.en) |-> (wr_s.addr[ADDR_W-1] != rel_s.bank))
    else $error("Payload written into the bank that is being streamed out.");

  a_single_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != STATUS_MEAS) |->
      (last_result_o && payload_byte_o == 8'h00))
    else $error("Reject or acknowledge result is not a single final result.");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("Verdict taken from an empty queue.");

endmodule

/* rtl/sfd_queue.sv */
module sfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfd_pkg::verdict_t push_data_i,
  input  logic              pop_i,
  output sfd_pkg::verdict_t head_o,
  output logic              empty_o,
  output logic              full_o
);
  import sfd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  verdict_t           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               do_push, do_pop;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/sfd_front.sv */
module sfd_front #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::DEF_MAX_FRAME_BYTES,
  parameter int HEADER_BYTES    = sfd_pkg::DEF_HEADER_BYTES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  input  logic                      frame_end_i,
  input  logic [sfd_pkg::CFG_W-1:0] ack_len_i,
  input  logic [sfd_pkg::CFG_W-1:0] meas_len_i,
  input  logic                      queue_full_i,
  input  sfd_pkg::rel_t             rel_i,
  output logic                      push_o,
  output sfd_pkg::verdict_t         verdict_o,
  output sfd_pkg::wr_t              wr_o
);
  import sfd_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0]     pos_q, pos_d;
  logic [7:0]           held_q, held_d;
  logic [7:0]           sum_q, sum_d;
  logic                 esc_q, esc_d;
  logic                 start_ok_q, start_ok_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 bank_q, bank_d;
  logic [NUM_BANKS-1:0] busy_q, busy_d;

  logic     accept;
  logic     put_en;
  logic [7:0] put_val;
  logic     frame_ok;
  unesc_t   unesc;

  assign in_stall_o = queue_full_i || busy_q[bank_q];
  assign accept     = in_valid_i && !in_stall_o;
  assign unesc      = unescape(held_q);

  always_comb begin
    pos_d      = pos_q;
    held_d     = held_q;
    sum_d      = sum_q;
    esc_d      = esc_q;
    start_ok_d = start_ok_q;
    cnt_d      = cnt_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    put_en     = 1'b0;
    put_val    = held_q;
    push_o     = 1'b0;
    verdict_o  = '{status: STATUS_REJECT, count: cnt_q, bank: bank_q};
    wr_o       = '{en: 1'b0, addr: {bank_q, cnt_q[IDX_W-1:0]}, data: held_q};
    frame_ok   = start_ok_q && (rx_byte_i == FLAG_BYTE) && (pos_q >= POS_W'(3)) &&
                 (pos_q < POS_W'(MAX_FRAME_BYTES)) && (~sum_q == held_q) &&
                 (cnt_q <= CNT_W'(PAYLOAD_DEPTH));

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept && !frame_end_i) begin
      if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
        if (pos_q == '0) begin
          start_ok_d = (rx_byte_i == FLAG_BYTE);
        end else begin
          if (pos_q >= POS_W'(2)) begin
            sum_d = sum_q + held_q;
            if (pos_q >= POS_W'(HEADER_BYTES + 1)) begin
              if (!esc_q) begin
                if (held_q == ESC_BYTE) begin
                  esc_d = 1'b1;
                end else begin
                  put_en = 1'b1;
                end
              end else begin
                esc_d   = 1'b0;
                put_en  = unesc.hit;
                put_val = unesc.value;
              end
            end
          end
          held_d = rx_byte_i;
        end
        pos_d = pos_q + 1'b1;
      end
      if (put_en) begin
        if (cnt_q < CNT_W'(PAYLOAD_DEPTH)) begin
          wr_o.en   = 1'b1;
          wr_o.data = put_val;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          cnt_d = CNT_W'(PAYLOAD_DEPTH + 1);
        end
      end
    end else if (accept) begin
      push_o = 1'b1;
      priority if (frame_ok && cnt_q == ack_len_i) begin
        verdict_o.status = STATUS_ACK;
      end else if (frame_ok && cnt_q == meas_len_i && cnt_q != '0) begin
        verdict_o.status = STATUS_MEAS;
        busy_d[bank_q]   = 1'b1;
        bank_d           = ~bank_q;
      end else begin
        verdict_o.status = STATUS_REJECT;
      end
      pos_d      = '0;
      held_d     = '0;
      sum_d      = '0;
      esc_d      = 1'b0;
      start_ok_d = 1'b0;
      cnt_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      held_q     <= '0;
      sum_q      <= '0;
      esc_q      <= 1'b0;
      start_ok_q <= 1'b0;
      cnt_q      <= '0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      held_q     <= held_d;
      sum_q      <= sum_d;
      esc_q      <= esc_d;
      start_ok_q <= start_ok_d;
      cnt_q      <= cnt_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

endmodule

/* rtl/sfd_back.sv */
module sfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfd_pkg::wr_t      wr_i,
  input  sfd_pkg::verdict_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output sfd_pkg::rel_t     rel_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        frame_status_o,
  output logic [7:0]        payload_byte_o,
  output logic              last_result_o
);
  import sfd_pkg::*;

  logic [7:0]        mem [NUM_BANKS * PAYLOAD_DEPTH];
  logic [7:0]        rd_data_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              s1_valid_q, s1_mem_q, s1_last_q;
  status_e           s1_status_q;
  logic              out_valid_q, out_last_q;
  status_e           out_status_q;
  logic [7:0]        out_byte_q;

  logic issue, s1_free, out_load, head_meas, last_rd;

  assign out_load  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free   = !s1_valid_q || out_load;
  assign issue     = !empty_i && s1_free;
  assign head_meas = (head_i.status == STATUS_MEAS);
  assign last_rd   = ({1'b0, idx_q} + 1'b1) == head_i.count;
  assign rd_en     = issue && head_meas;
  assign rd_addr   = {head_i.bank, idx_q};
  assign pop_o     = issue && (!head_meas || last_rd);
  assign rel_o     = '{valid: rd_en && last_rd, bank: head_i.bank};

  always_comb begin
    idx_d = idx_q;
    if (rd_en) begin
      idx_d = last_rd ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (s1_free) begin
        s1_valid_q <= issue;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_status_q <= head_i.status;
      s1_mem_q    <= head_meas;
      s1_last_q   <= head_meas ? last_rd : 1'b1;
    end
    if (out_load) begin
      out_status_q <= s1_status_q;
      out_byte_q   <= s1_mem_q ? rd_data_q : 8'h00;
      out_last_q   <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = out_status_q;
  assign payload_byte_o = out_byte_q;
  assign last_result_o  = out_last_q;

endmodule

/* dv/stuffed_frame_deframer_test.sv */
`timescale 1ns / 100ps

module stuffed_frame_deframer_test;
  import sfd_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_BYTES    = 24;
  localparam int NUM_PHASES     = 6;
  localparam int DIRECTED_ROWS  = 24;
  localparam int HEADER_LEN     = DEF_HEADER_BYTES;
  localparam int FRAME_LIMIT    = DEF_MAX_FRAME_BYTES;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       typed;
    status_e    status;
  } directed_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] ack_len;
    logic [CFG_W-1:0] meas_len;
  } length_pair_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_index_i = REG_ACK_LENGTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [7:0]       rx_byte_i   = 8'h00;
  logic             frame_end_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       frame_status_o;
  logic [7:0]       payload_byte_o;
  logic             last_result_o;

  stuffed_frame_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_status_o (frame_status_o),
    .payload_byte_o (payload_byte_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #HALF_PERIOD;
    clk_i = ~clk_i;
  end

  // Shadow of the deframer state.
  int unsigned      frame_pos;
  logic [7:0]       held_q;
  logic [7:0]       sum_q;
  bit               esc_q;
  bit               start_seen;
  int unsigned      pay_cnt;
  logic [7:0]       pay_mem [PAYLOAD_DEPTH];
  logic [CFG_W-1:0] ack_len_q  = ACK_LEN_RESET;
  logic [CFG_W-1:0] meas_len_q = MEAS_LEN_RESET;

  frame_beat_t expected_beats [$];
  int          mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned bytes_offered  = 0;

  length_pair_t length_plan [NUM_PHASES] = '{
    '{7'd0,  7'd64},
    '{7'd64, 7'd1},
    '{7'd7,  7'd7},
    '{7'd2,  7'd0},
    '{7'd63, 7'd12},
    '{7'd1,  7'd40}
  };

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h7E, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7E, 1'b1, 1'b1, STATUS_REJECT},
    '{8'h7E, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h01, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h02, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h03, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h04, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h10, 1'b0, 1'b0, STATUS_REJECT},
    '{8'hE5, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7E, 1'b1, 1'b1, STATUS_ACK},
    '{8'h00, 1'b0, 1'b0, STATUS_REJECT},
    '{8'hFF, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h00, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7E, 1'b1, 1'b1, STATUS_REJECT},
    '{8'h7E, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7D, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h00, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h00, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h00, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7D, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h5E, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7D, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h2A, 1'b0, 1'b0, STATUS_REJECT},
    '{8'h7E, 1'b1, 1'b0, STATUS_REJECT}
  };

  function automatic void clear_frame_state();
    frame_pos  = 0;
    held_q     = 8'h00;
    sum_q      = 8'h00;
    esc_q      = 1'b0;
    start_seen = 1'b0;
    pay_cnt    = 0;
  endfunction

  function automatic void store_payload(logic [7:0] b);
    if (pay_cnt < PAYLOAD_DEPTH) begin
      pay_mem[pay_cnt] = b;
      pay_cnt++;
    end else begin
      pay_cnt = PAYLOAD_DEPTH + 1;
    end
  endfunction

  function automatic void fold_byte(logic [7:0] b, int unsigned pos);
    sum_q = sum_q + b;
    if (pos < HEADER_LEN) return;
    if (!esc_q) begin
      if (b == ESC_BYTE) esc_q = 1'b1;
      else store_payload(b);
    end else begin
      esc_q = 1'b0;
      case (b)
        ESC_FLAG: store_payload(FLAG_BYTE);
        ESC_ESC:  store_payload(ESC_BYTE);
        ESC_XON:  store_payload(XON_BYTE);
        ESC_XOFF: store_payload(XOFF_BYTE);
        default: ;
      endcase
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic fend);
    int unsigned frame_len;
    bit          frame_ok;
    if (!fend) begin
      if (frame_pos < FRAME_LIMIT) begin
        if (frame_pos == 0) begin
          start_seen = (b == FLAG_BYTE);
        end else begin
          if (frame_pos >= 2) fold_byte(held_q, frame_pos - 1);
          held_q = b;
        end
        frame_pos++;
      end
      return;
    end
    frame_len = frame_pos + 1;
    frame_ok  = start_seen && b == FLAG_BYTE && frame_len >= 4 && frame_len <= FRAME_LIMIT &&
                ~sum_q == held_q && pay_cnt <= PAYLOAD_DEPTH;
    if (frame_ok && pay_cnt == ack_len_q) begin
      expected_beats.push_back('{STATUS_ACK, 8'h00, 1'b1});
    end else if (frame_ok && pay_cnt == meas_len_q && pay_cnt > 0) begin
      for (int k = 0; k < pay_cnt; k++) begin
        expected_beats.push_back('{STATUS_MEAS, pay_mem[k], k == pay_cnt - 1});
      end
    end else begin
      expected_beats.push_back('{STATUS_REJECT, 8'h00, 1'b1});
    end
    clear_frame_state();
  endfunction

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic fend, input bit typed = 1'b0,
                           input status_e typed_status = STATUS_REJECT);
    int unsigned queued;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= fend;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queued = expected_beats.size();
    deframe_byte(b, fend);
    if (typed) begin
      while (expected_beats.size() > queued) void'(expected_beats.pop_back());
      expected_beats.push_back('{typed_status, 8'h00, 1'b1});
    end
    bytes_offered++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_lengths(input length_pair_t lens);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ACK_LENGTH;
    cfg_wdata_i <= lens.ack_len;
    @(negedge clk_i);
    cfg_index_i <= REG_MEAS_LENGTH;
    cfg_wdata_i <= lens.meas_len;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    ack_len_q  = lens.ack_len;
    meas_len_q = lens.meas_len;
  endtask

  function automatic logic [7:0] special_byte();
    case ($urandom_range(3))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return XON_BYTE;
      default: return XOFF_BYTE;
    endcase
  endfunction

  function automatic logic [7:0] stuff_code(logic [7:0] v);
    case (v)
      FLAG_BYTE: return ESC_FLAG;
      ESC_BYTE:  return ESC_ESC;
      XON_BYTE:  return ESC_XON;
      default:   return ESC_XOFF;
    endcase
  endfunction

  task automatic send_random_frame();
    logic [7:0]  raw [$];
    logic [7:0]  v;
    logic [7:0]  csum;
    int unsigned pick;
    int unsigned pay_len;
    int unsigned made;
    pick = $urandom_range(99);
    raw.push_back(FLAG_BYTE);
    if (pick < 89) begin
      repeat (HEADER_LEN - 1) raw.push_back(8'($urandom_range(255)));
      case ($urandom_range(9))
        0, 1, 2: pay_len = ack_len_q;
        3, 4, 5: pay_len = meas_len_q;
        9:       pay_len = $urandom_range(59);
        default: pay_len = $urandom_range(10);
      endcase
      made = 0;
      while (made < pay_len && raw.size() <= 60) begin
        if ($urandom_range(11) == 0) begin
          v = 8'($urandom_range(255));
          if (v == ESC_FLAG || v == ESC_ESC || v == ESC_XON || v == ESC_XOFF) v = 8'h00;
          raw.push_back(ESC_BYTE);
          raw.push_back(v);
        end else begin
          v = ($urandom_range(3) == 0) ? special_byte() : 8'($urandom_range(255));
          if (v == FLAG_BYTE || v == ESC_BYTE ||
              ((v == XON_BYTE || v == XOFF_BYTE) && $urandom_range(1) == 1)) begin
            raw.push_back(ESC_BYTE);
            raw.push_back(stuff_code(v));
          end else begin
            raw.push_back(v);
          end
          made++;
        end
      end
      if (pick >= 86) raw.push_back(ESC_BYTE);
      csum = 8'h00;
      for (int i = 1; i < raw.size(); i++) csum = csum + raw[i];
      csum = ~csum;
      if (pick >= 72 && pick < 78) csum = csum ^ 8'($urandom_range(1, 255));
      raw.push_back(csum);
      raw.push_back(FLAG_BYTE);
      if (pick >= 78 && pick < 82) raw[0] = FLAG_BYTE ^ 8'($urandom_range(1, 255));
      if (pick >= 82 && pick < 86) raw[raw.size() - 1] = FLAG_BYTE ^ 8'($urandom_range(1, 255));
    end else if (pick < 92) begin
      repeat ($urandom_range(FRAME_LIMIT, FRAME_LIMIT + 12)) raw.push_back(8'($urandom_range(255)));
      raw.push_back(FLAG_BYTE);
    end else begin
      if ($urandom_range(1) == 0) raw[0] = 8'($urandom_range(255));
      repeat ($urandom_range(11)) raw.push_back(8'($urandom_range(255)));
      if ($urandom_range(1) == 0) raw[raw.size() - 1] = FLAG_BYTE;
    end
    foreach (raw[i]) send_byte(raw[i], i == raw.size() - 1);
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    clear_frame_state();
    @(negedge clk_i);
    send_idle_pct  = 38;
    recv_stall_pct = 77;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].fend, directed_rows[i].typed,
                directed_rows[i].status);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_lengths(length_plan[p]);
      case (p / 2)
        0: begin
          send_idle_pct  = 38;
          recv_stall_pct = 77;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (p == 4) hold_req = 1'b1;
      phase_end = bytes_offered + PHASE_BYTES;
      while (bytes_offered < phase_end || hold_req) send_random_frame();
    end
    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_receiver
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $error("Unexpected transfer: frame_status %0d, payload_byte %h, last_result %b",
               frame_status_o, payload_byte_o, last_result_o);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (frame_status_o !== want.status) begin
          $error("frame_status: expected %0d, got %0d", want.status, frame_status_o);
          mismatch_count++;
        end
        if (payload_byte_o !== want.data) begin
          $error("payload_byte: expected %h, got %h", want.data, payload_byte_o);
          mismatch_count++;
        end
        if (last_result_o !== want.last) begin
          $error("last_result: expected %b, got %b", want.last, last_result_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
